@@ design/ewh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equal-width histogram package
// Field widths, register codes, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package ewh_pkg;

   localparam int MAX_CLASSES_DEF = 64;

   localparam int VALUE_W = 32;
   localparam int WIDTH_W = 31;
   localparam int NCLS_W  = 7;
   localparam int COUNT_W = 32;
   localparam int INDEX_W = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam int SQUARE_W   = 64;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALUE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_WIDTH = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLASSES = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_MODE = 4'd3;

   // operation codes on the sample channel
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic signed [VALUE_W-1:0] MIN_VALUE_RST   = 32'sd0;
   localparam logic [WIDTH_W-1:0]        CLASS_WIDTH_RST = 31'd65536;
   localparam logic [NCLS_W-1:0]         NUM_CLASSES_RST = 7'd10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic signed [VALUE_W-1:0] min_value;
      logic [WIDTH_W-1:0]        class_width;
      logic [NCLS_W-1:0]         num_classes;
      logic                      length_mode;
   } cfg_type;

endpackage

@@ design/ewh_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equal-width histogram channels
// Sample, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ewh_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic                                masked;
   logic signed [ewh_pkg::VALUE_W-1:0]  value_x;
   logic signed [ewh_pkg::VALUE_W-1:0]  value_y;
   logic signed [ewh_pkg::VALUE_W-1:0]  value_z;

   modport source (output valid, func, masked, value_x, value_y, value_z, input ready);
   modport sink   (input valid, func, masked, value_x, value_y, value_z, output ready);
endinterface

interface ewh_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ewh_pkg::INDEX_W-1:0]         bin_index;
   logic signed [ewh_pkg::VALUE_W-1:0]  bin_lower;
   logic [ewh_pkg::COUNT_W-1:0]         bin_count;
   logic [ewh_pkg::COUNT_W-1:0]         peak_count;
   logic                                last;

   modport source (output valid, bin_index, bin_lower, bin_count, peak_count, last,
                   input ready);
   modport sink   (input valid, bin_index, bin_lower, bin_count, peak_count, last,
                   output ready);
endinterface

interface ewh_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ewh_pkg::CSR_IDX_W-1:0]       index;
   logic [ewh_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/ewh_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ewh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ewh_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared squaring unit
// Registered 32 x 32 unsigned square, used for components and class edges.
// ----------------------------------------------------------------------------
module ewh_mul (
   input  logic                                clock,
   input  logic                                en,
   input  logic [ewh_pkg::VALUE_W-1:0]         operand,
   output logic [ewh_pkg::SQUARE_W-1:0]        product
);

   logic [ewh_pkg::SQUARE_W-1:0] product_ff;

   // hold the last product until the next issue
   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= ewh_pkg::SQUARE_W'(operand) * ewh_pkg::SQUARE_W'(operand);
      end
   end

   assign product = product_ff;

endmodule

@@ design/ewh_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equal-width histogram register file
// Holds the class layout and mode, written through the register channel.
// ----------------------------------------------------------------------------
module ewh_csr (
   input  logic              clock,
   input  logic              reset,
   ewh_csr_if.sink           csr_chan,
   output ewh_pkg::cfg_type  cfg
);

   ewh_pkg::cfg_type cfg_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_value   <= ewh_pkg::MIN_VALUE_RST;
         cfg_ff.class_width <= ewh_pkg::CLASS_WIDTH_RST;
         cfg_ff.num_classes <= ewh_pkg::NUM_CLASSES_RST;
         cfg_ff.length_mode <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            ewh_pkg::CSR_MIN_VALUE: begin
               cfg_ff.min_value <= $signed(csr_chan.data[ewh_pkg::VALUE_W-1:0]);
            end
            ewh_pkg::CSR_CLASS_WIDTH: begin
               cfg_ff.class_width <= csr_chan.data[ewh_pkg::WIDTH_W-1:0];
            end
            ewh_pkg::CSR_NUM_CLASSES: begin
               cfg_ff.num_classes <= csr_chan.data[ewh_pkg::NCLS_W-1:0];
            end
            ewh_pkg::CSR_LENGTH_MODE: begin
               cfg_ff.length_mode <= csr_chan.data[0];
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/equal_width_histogram.sv @@
`timescale 1ns / 1ps
// Scan: a scalar sample steps edge and compare per class, a length sample first squares and sums
// its components, then edge, square and compare per class; a hit adds an update, a masked sample no scan.
// Flush: reads, loads and presents each class in use in turn, one result each, held until taken.
// One item at a time: the next is taken only back in idle, after the edge scan through the shared adder/squarer.
// Reset: synchronous, active high; clears counts, peak and the configuration registers to their defaults.
// No clearing pass: count valid bits are cleared at once by reset and by each flush.
// ----------------------------------------------------------------------------
// Equal-width histogram
// Counts samples into equal-width classes and reports all classes in use on a flush.
// ----------------------------------------------------------------------------
module equal_width_histogram #(
   parameter int MAX_CLASSES = ewh_pkg::MAX_CLASSES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ewh_req_if.sink   req_chan,
   ewh_rsp_if.source rsp_chan,
   ewh_csr_if.sink   csr_chan
);

   // index width of the count store and width of an exact class edge
   localparam int IDX_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int EDGE_W = 34 + $clog2(MAX_CLASSES);
   localparam int VW     = ewh_pkg::VALUE_W;
   localparam int CW     = ewh_pkg::COUNT_W;
   localparam int SW     = ewh_pkg::SQUARE_W;
   localparam logic [8:0] MAX_NUM = 9'(MAX_CLASSES);
   localparam logic [8:0] MAX_M1  = 9'(MAX_CLASSES - 1);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_SQ_MUL  = 10'b00_0000_0010,
      ST_SQ_ACC  = 10'b00_0000_0100,
      ST_SC_EDGE = 10'b00_0000_1000,
      ST_SC_MUL  = 10'b00_0001_0000,
      ST_SC_CMP  = 10'b00_0010_0000,
      ST_UPD     = 10'b00_0100_0000,
      ST_FL_RD   = 10'b00_1000_0000,
      ST_FL_LOAD = 10'b01_0000_0000,
      ST_FL_WAIT = 10'b10_0000_0000
   } state_type;

   ewh_pkg::cfg_type cfg;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic signed [EDGE_W-1:0]  edge_ff, edge_in;
   logic [SW-1:0]             len2_ff, len2_in;
   logic [1:0]                sel_ff, sel_in;
   logic signed [VW-1:0]      x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [MAX_CLASSES-1:0]    valid_ff, valid_in;
   logic [CW-1:0]             peak_ff, peak_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ewh_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic signed [VW-1:0]      rsp_lower_ff, rsp_lower_in;
   logic [CW-1:0]             rsp_count_ff, rsp_count_in;
   logic [CW-1:0]             rsp_peak_ff, rsp_peak_in;
   logic                      rsp_last_ff, rsp_last_in;

   // shared arithmetic and store ports
   logic signed [EDGE_W-1:0]  cw_ext, min_ext, edge_sum, x_ext;
   logic [8:0]                num_ext, last_lim;
   logic [IDX_W-1:0]          n_last;
   logic                      mul_en;
   logic [VW-1:0]             mul_op, comp_abs;
   logic signed [VW-1:0]      comp_sel;
   logic [SW-1:0]             product;
   logic                      rd_en, wr_en;
   logic [CW-1:0]             rd_data, cur_count, upd_count;
   logic                      edge_big, below, sat_hi, sat_lo;
   logic                      req_fire, rsp_fire;

   ewh_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ewh_mul u_mul (
      .clock   (clock),
      .en      (mul_en),
      .operand (mul_op),
      .product (product)
   );

   ewh_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_CLASSES)
   ) u_counts (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (upd_count),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.bin_index  = rsp_index_ff;
   assign rsp_chan.bin_lower  = rsp_lower_ff;
   assign rsp_chan.bin_count  = rsp_count_ff;
   assign rsp_chan.peak_count = rsp_peak_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // last class in use: zero counts as one, large counts clip to the store depth
   assign num_ext  = 9'(cfg.num_classes);
   assign last_lim = (num_ext == 9'd0) ? 9'd0 :
                     (num_ext > MAX_NUM) ? MAX_M1 : (num_ext - 9'd1);
   assign n_last   = IDX_W'(last_lim);

   // one adder walks the class edges, for the scan and for the flush alike
   assign cw_ext   = {{(EDGE_W - ewh_pkg::WIDTH_W){1'b0}}, cfg.class_width};
   assign min_ext  = {{(EDGE_W - VW){cfg.min_value[VW-1]}}, cfg.min_value};
   assign edge_sum = edge_ff + cw_ext;
   assign x_ext    = {{(EDGE_W - VW){x_ff[VW-1]}}, x_ff};

   // magnitude of the component being squared
   always_comb begin
      case (sel_ff)
         2'd0:    comp_sel = x_ff;
         2'd1:    comp_sel = y_ff;
         default: comp_sel = z_ff;
      endcase
   end
   assign comp_abs = comp_sel[VW-1] ? (~comp_sel + 1'b1) : comp_sel;

   assign mul_en = (state_ff == ST_SQ_MUL) || (state_ff == ST_SC_MUL);
   assign mul_op = (state_ff == ST_SC_MUL) ? edge_ff[VW-1:0] : comp_abs;

   // edge at or above 2^32 holds every length; a non-positive edge holds none
   assign edge_big = !edge_ff[EDGE_W-1] && (|edge_ff[EDGE_W-2:VW]);
   always_comb begin
      if (!cfg.length_mode) begin
         below = x_ext < edge_ff;
      end else if (edge_ff[EDGE_W-1] || (edge_ff == '0)) begin
         below = 1'b0;
      end else if (edge_big) begin
         below = 1'b1;
      end else begin
         below = len2_ff < product;
      end
   end

   // clip the reported lower edge to the signed 32-bit range
   assign sat_hi = !edge_ff[EDGE_W-1] && (|edge_ff[EDGE_W-2:VW-1]);
   assign sat_lo = edge_ff[EDGE_W-1] && !(&edge_ff[EDGE_W-2:VW-1]);

   // an entry never written since reset or the last flush reads as zero
   assign cur_count = valid_ff[idx_ff] ? rd_data : '0;
   assign upd_count = (cur_count == ewh_pkg::COUNT_MAX) ? cur_count : (cur_count + 1'b1);

   assign rd_en = (state_ff == ST_SC_CMP) || (state_ff == ST_FL_RD);
   assign wr_en = (state_ff == ST_UPD);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      edge_in      = edge_ff;
      len2_in      = len2_ff;
      sel_in       = sel_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      valid_in     = valid_ff;
      peak_in      = peak_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_lower_in = rsp_lower_ff;
      rsp_count_in = rsp_count_ff;
      rsp_peak_in  = rsp_peak_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in  = '0;
               edge_in = min_ext;
               x_in    = req_chan.value_x;
               y_in    = req_chan.value_y;
               z_in    = req_chan.value_z;
               len2_in = '0;
               sel_in  = 2'd0;
               if (req_chan.func == ewh_pkg::OP_FLUSH) begin
                  state_in = ST_FL_RD;
               end else if (!req_chan.masked) begin
                  state_in = cfg.length_mode ? ST_SQ_MUL : ST_SC_EDGE;
               end
            end
         end
         ST_SQ_MUL: begin
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            // accumulate the squared length one component at a time
            len2_in = len2_ff + product;
            if (sel_ff == 2'd2) begin
               state_in = ST_SC_EDGE;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_SC_EDGE: begin
            // advance to this class's upper edge
            edge_in  = edge_sum;
            state_in = cfg.length_mode ? ST_SC_MUL : ST_SC_CMP;
         end
         ST_SC_MUL: begin
            state_in = ST_SC_CMP;
         end
         ST_SC_CMP: begin
            if (below) begin
               state_in = ST_UPD;
            end else if (idx_ff == n_last) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SC_EDGE;
            end
         end
         ST_UPD: begin
            valid_in[idx_ff] = 1'b1;
            if (upd_count > peak_ff) begin
               peak_in = upd_count;
            end
            state_in = ST_IDLE;
         end
         ST_FL_RD: begin
            state_in = ST_FL_LOAD;
         end
         ST_FL_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = ewh_pkg::INDEX_W'(idx_ff);
            rsp_lower_in = sat_hi ? {1'b0, {(VW - 1){1'b1}}} :
                           sat_lo ? {1'b1, {(VW - 1){1'b0}}} : edge_ff[VW-1:0];
            rsp_count_in = cur_count;
            rsp_peak_in  = peak_ff;
            rsp_last_in  = (idx_ff == n_last);
            state_in     = ST_FL_WAIT;
         end
         ST_FL_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  // drop every count, in use or not, and the peak
                  valid_in = '0;
                  peak_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  edge_in  = edge_sum;
                  state_in = ST_FL_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath registers hold without reset
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      edge_ff      <= edge_in;
      len2_ff      <= len2_in;
      sel_ff       <= sel_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      rsp_index_ff <= rsp_index_in;
      rsp_lower_ff <= rsp_lower_in;
      rsp_count_ff <= rsp_count_in;
      rsp_peak_ff  <= rsp_peak_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_rsp_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_FL_WAIT))
      else $error("result presented outside the flush wait state");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_ff) |=> ((valid_ff == '0) && (peak_ff == '0)))
      else $error("counts or peak not cleared after the final class transfer");

   a_peak_tracks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |=> (peak_ff >= $past(upd_count)))
      else $error("peak below an updated count");

   a_index_in_use: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SC_CMP) || (state_ff == ST_FL_RD)) |-> (idx_ff <= n_last))
      else $error("class index beyond the classes in use");
`endif

endmodule

@@ verif/ewh_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equal-width histogram scoreboard
// Watches the register, sample and report channels, keeps its own copy of the
// class counts and checks each flush report in order against it.
// ----------------------------------------------------------------------------
module ewh_scoreboard (
   input  logic        clock,
   input  logic        reset,
   ewh_req_if          req_chan,
   ewh_rsp_if          rsp_chan,
   ewh_csr_if          csr_chan,
   output int unsigned fail_count,
   output int unsigned reports_due
);
   import ewh_pkg::*;

   localparam int     REPORT_LIMIT = 10;
   localparam longint EDGE_MAX     = 64'sd2147483647;
   localparam longint EDGE_MIN     = -64'sd2147483648;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        bin_index;
      logic signed [VALUE_W-1:0] bin_lower;
      logic [COUNT_W-1:0]        bin_count;
      logic [COUNT_W-1:0]        peak_count;
      logic                      last;
   } bin_report_type;

   cfg_type            cfg;
   logic [COUNT_W-1:0] tally [MAX_CLASSES_DEF];
   logic [COUNT_W-1:0] peak;
   bin_report_type     report_q[$];
   int unsigned        mismatches = 0;

   function automatic int unsigned classes_active();
      int unsigned n;
      n = 32'(cfg.num_classes);
      if (n < 1) n = 1;
      if (n > MAX_CLASSES_DEF) n = MAX_CLASSES_DEF;
      return n;
   endfunction

   function automatic u64_type square_mag(logic signed [VALUE_W-1:0] v);
      longint  m;
      u64_type a;
      m = longint'(v);
      if (m < 0) m = -m;
      a = u64_type'(m);
      return a * a;
   endfunction

   // an edge at or above 2^32 squares past any length of three components
   function automatic bit sample_below(longint upper, longint val, u64_type len2);
      u64_type e;
      if (!cfg.length_mode) return val < upper;
      if (upper <= 0) return 1'b0;
      if (upper >= 64'sh1_0000_0000) return 1'b1;
      e = u64_type'(upper);
      return len2 < e * e;
   endfunction

   function automatic void count_sample(logic signed [VALUE_W-1:0] x, y, z);
      longint      upper;
      longint      val;
      u64_type     len2;
      int unsigned n;
      bit          placed;
      n      = classes_active();
      val    = longint'(x);
      upper  = longint'($signed(cfg.min_value));
      len2   = 0;
      placed = 1'b0;
      if (cfg.length_mode) len2 = square_mag(x) + square_mag(y) + square_mag(z);
      for (int j = 0; j < n && !placed; j++) begin
         upper += longint'(cfg.class_width);
         if (sample_below(upper, val, len2)) begin
            placed = 1'b1;
            if (tally[j] != COUNT_MAX) tally[j]++;
            if (tally[j] > peak) peak = tally[j];
         end
      end
   endfunction

   function automatic void emit_reports();
      bin_report_type r;
      longint         lower;
      int unsigned    n;
      n = classes_active();
      for (int j = 0; j < n; j++) begin
         lower = longint'($signed(cfg.min_value)) + longint'(j) * longint'(cfg.class_width);
         if (lower > EDGE_MAX) lower = EDGE_MAX;
         if (lower < EDGE_MIN) lower = EDGE_MIN;
         r.bin_index  = INDEX_W'(j);
         r.bin_lower  = lower[VALUE_W-1:0];
         r.bin_count  = tally[j];
         r.peak_count = peak;
         r.last       = (j == n - 1);
         report_q.push_back(r);
      end
      foreach (tally[i]) tally[i] = '0;
      peak = '0;
   endfunction

   function automatic void write_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_MIN_VALUE:   cfg.min_value   = val;
         CSR_CLASS_WIDTH: cfg.class_width = val[WIDTH_W-1:0];
         CSR_NUM_CLASSES: cfg.num_classes = val[NCLS_W-1:0];
         CSR_LENGTH_MODE: cfg.length_mode = val[0];
         default: ;
      endcase
   endfunction

   function automatic void log_mismatch(string what, bin_report_type got,
                                        bin_report_type want);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t %s: expected index %0d lower %h count %0d peak %0d last %b",
                  $time, what, want.bin_index, want.bin_lower, want.bin_count,
                  want.peak_count, want.last);
         $display("%0t %s: actual   index %0d lower %h count %0d peak %0d last %b",
                  $time, what, got.bin_index, got.bin_lower, got.bin_count,
                  got.peak_count, got.last);
      end
   endfunction

   function automatic void check_report();
      bin_report_type got;
      bin_report_type want;
      got.bin_index  = rsp_chan.bin_index;
      got.bin_lower  = rsp_chan.bin_lower;
      got.bin_count  = rsp_chan.bin_count;
      got.peak_count = rsp_chan.peak_count;
      got.last       = rsp_chan.last;
      if (report_q.size() == 0) begin
         log_mismatch("report with none pending", got, '0);
      end else begin
         want = report_q.pop_front();
         if (got !== want) log_mismatch("report differs", got, want);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{min_value: MIN_VALUE_RST, class_width: CLASS_WIDTH_RST,
                 num_classes: NUM_CLASSES_RST, length_mode: 1'b0};
         foreach (tally[i]) tally[i] = '0;
         peak = '0;
         report_q.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) write_register(csr_chan.index, csr_chan.data);
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.func == OP_FLUSH) emit_reports();
            else if (!req_chan.masked)
               count_sample(req_chan.value_x, req_chan.value_y, req_chan.value_z);
         end
         if (rsp_chan.valid && rsp_chan.ready) check_report();
      end
      reports_due <= report_q.size();
      fail_count  <= mismatches;
   end

endmodule

@@ verif/equal_width_histogram_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equal-width histogram testbench
// Drives register writes, samples and flushes into the histogram, stalls both
// channels at random and leaves all checking to the scoreboard beside it.
// ----------------------------------------------------------------------------
module equal_width_histogram_tb;
   import ewh_pkg::*;

   localparam int RESET_CYCLES    = 8;
   localparam int IDLE_PERCENT    = 7;
   // longest scan is a length sample over 64 classes
   localparam int SCAN_PAUSE      = 240;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 11;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned reports_due;
   bit          steady;          // both sides transfer without idling while set
   int unsigned hold_asks = 0;   // each step asks the report side for a long hold-off

   // register settings as last written, used to aim samples at the classes
   logic [31:0]        cur_min     = MIN_VALUE_RST;
   logic [WIDTH_W-1:0] cur_width   = CLASS_WIDTH_RST;
   logic [NCLS_W-1:0]  cur_classes = NUM_CLASSES_RST;
   logic               cur_mode    = 1'b0;

   ewh_req_if req_chan ();
   ewh_rsp_if rsp_chan ();
   ewh_csr_if csr_chan ();

   equal_width_histogram u_dut (
      .clock,
      .reset,
      .req_chan,
      .rsp_chan,
      .csr_chan
   );

   ewh_scoreboard u_scoreboard (
      .clock,
      .reset,
      .req_chan,
      .rsp_chan,
      .csr_chan,
      .fail_count,
      .reports_due
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Write all four registers back to back; valid stays high between writes
   // and drops only after the last transfer.
   task automatic configure(logic [31:0] min_v, logic [WIDTH_W-1:0] width_v,
                            logic [NCLS_W-1:0] classes_v, logic mode_v);
      logic [CSR_IDX_W-1:0]  idx  [4];
      logic [CSR_DATA_W-1:0] data [4];
      idx  = '{CSR_MIN_VALUE, CSR_CLASS_WIDTH, CSR_NUM_CLASSES, CSR_LENGTH_MODE};
      data = '{min_v, 32'(width_v), 32'(classes_v), 32'(mode_v)};
      foreach (idx[i]) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx[i];
         csr_chan.data  <= data[i];
         @(posedge clock);
         while (!csr_chan.ready) @(posedge clock);
      end
      csr_chan.valid <= 1'b0;
      cur_min     = min_v;
      cur_width   = width_v;
      cur_classes = classes_v;
      cur_mode    = mode_v;
   endtask

   // Offer one item and return at the edge of its transfer. Valid is left
   // high so that the next item can follow without a gap.
   task automatic send_req(logic op, logic skip, logic [31:0] x, y, z);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.func    <= op;
      req_chan.masked  <= skip;
      req_chan.value_x <= x;
      req_chan.value_y <= y;
      req_chan.value_z <= z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Drop valid, wait for every pending report, then let a sample still in
   // its edge scan finish before anything else is written.
   task automatic drain(int unsigned limit);
      int unsigned waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SCAN_PAUSE) @(posedge clock);
   endtask

   // Report side: ready at random, or held low for a long count on request.
   initial begin
      int unsigned holds_done;
      holds_done     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [31:0]        min_v;
      logic [WIDTH_W-1:0] width_v;
      logic [NCLS_W-1:0]  classes_v;
      logic [31:0]        x;
      logic [31:0]        y;
      logic [31:0]        z;
      longint             target;
      int unsigned        pick;

      reset            = 1'b1;
      steady           = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.func    = OP_ADD;
      req_chan.masked  = 1'b0;
      req_chan.value_x = '0;
      req_chan.value_y = '0;
      req_chan.value_z = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = CSR_MIN_VALUE;
      csr_chan.data    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: ten unit classes from zero, scalar samples.
      send_req(OP_ADD, 1'b0, 32'hFFFF_FFFF, $urandom, $urandom);  // below range: class 0
      send_req(OP_ADD, 1'b0, 32'h0000_0000, $urandom, $urandom);  // on the lower edge
      send_req(OP_ADD, 1'b0, 32'h0001_0000, $urandom, $urandom);  // first edge: class 1
      send_req(OP_ADD, 1'b0, 32'h0009_FFFF, $urandom, $urandom);  // just inside the top class
      send_req(OP_ADD, 1'b0, 32'h000A_0000, $urandom, $urandom);  // top edge: dropped
      send_req(OP_ADD, 1'b0, 32'h7FFF_FFFF, $urandom, $urandom);  // largest value: dropped
      send_req(OP_ADD, 1'b0, 32'h8000_0000, $urandom, $urandom);  // smallest value: class 0
      send_req(OP_ADD, 1'b1, 32'h0002_0000, $urandom, $urandom);  // masked, no count
      send_req(OP_FLUSH, 1'b1, $urandom, $urandom, $urandom);     // mask ignored on flush
      drain(DRAIN_LIMIT);

      // Lowest lower edge, widest class, class count zero taken as one.
      configure(32'h8000_0000, '1, 7'd0, 1'b0);
      send_req(OP_ADD, 1'b0, 32'h8000_0000, $urandom, $urandom);
      send_req(OP_ADD, 1'b0, 32'hFFFF_FFFE, $urandom, $urandom);  // just below the edge at -1
      send_req(OP_ADD, 1'b0, 32'hFFFF_FFFF, $urandom, $urandom);  // on it: dropped
      send_req(OP_FLUSH, 1'b0, $urandom, $urandom, $urandom);
      drain(DRAIN_LIMIT);

      // Length mode from -2.0, so the first two upper edges hold nothing;
      // class count beyond the limit. No flush: the counts carry over.
      configure(32'hFFFE_0000, 31'h0001_0000, 7'h7F, 1'b1);
      send_req(OP_ADD, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_req(OP_ADD, 1'b0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
      send_req(OP_ADD, 1'b0, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000);
      send_req(OP_ADD, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      drain(DRAIN_LIMIT);

      // Three classes now: the count left in class 3 still sets the peak.
      // Edges run past 2^32 and the lower edges saturate.
      configure(32'h7FFF_FFFF, 31'h4000_0001, 7'd3, 1'b1);
      send_req(OP_ADD, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_req(OP_ADD, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_req(OP_ADD, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_req(OP_FLUSH, 1'b1, $urandom, $urandom, $urandom);
      drain(DRAIN_LIMIT);

      // Zero class width: every upper edge sits on the lower edge.
      configure(32'h0000_0100, '0, 7'd5, 1'b0);
      send_req(OP_ADD, 1'b0, 32'h0000_00FF, $urandom, $urandom);
      send_req(OP_ADD, 1'b0, 32'h0000_0100, $urandom, $urandom);
      send_req(OP_ADD, 1'b0, 32'h8000_0000, $urandom, $urandom);
      send_req(OP_FLUSH, 1'b0, $urandom, $urandom, $urandom);
      drain(DRAIN_LIMIT);

      // Random phases: fresh settings each time, mostly small class counts,
      // mostly samples aimed at the classes in use.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         min_v = $urandom;
         if ($urandom_range(0, 3) != 0) min_v = {{14{min_v[17]}}, min_v[17:0]};
         case ($urandom_range(0, 9))
            0:       width_v = '0;
            1:       width_v = '1;
            2:       width_v = WIDTH_W'($urandom);
            default: width_v = WIDTH_W'($urandom_range(1, 32'h0004_0000));
         endcase
         case ($urandom_range(0, 7))
            0:       classes_v = NCLS_W'($urandom_range(0, 127));
            1:       classes_v = 7'd64;
            default: classes_v = NCLS_W'($urandom_range(1, 16));
         endcase
         // full-size flush for the back-pressure phase
         if (phase == 2) classes_v = 7'd64;
         configure(min_v, width_v, classes_v, 1'($urandom_range(0, 1)));
         steady = (phase == 4);

         for (int item = 0; item < PHASE_ITEMS; item++) begin
            if (phase == 2 && item == 4) begin
               // hold the report side off so the flush backs up and the
               // samples behind it stall at the input
               hold_asks++;
               send_req(OP_FLUSH, 1'b0, $urandom, $urandom, $urandom);
            end
            x    = $urandom;
            y    = $urandom;
            z    = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_req(OP_FLUSH, pick[0], x, y, z);
            end else if (pick < 16) begin
               send_req(OP_ADD, 1'b1, x, y, z);
            end else if (pick < 30) begin
               send_req(OP_ADD, 1'b0, x, y, z);
            end else begin
               // from one class below the range to one above it
               target = longint'($signed(cur_min))
                      + (longint'($urandom_range(0, cur_classes + 1)) - 1)
                        * longint'(cur_width);
               if (cur_width != 0) target += longint'($urandom_range(0, cur_width - 1));
               if (cur_mode) begin
                  // radius near the target, nudged by small side components
                  if (target < 0) target = -target;
                  y = int'($urandom_range(0, 511)) - 256;
                  z = int'($urandom_range(0, 511)) - 256;
               end
               x = target[31:0];
               if (cur_mode && $urandom_range(0, 1)) x = -x;
               send_req(OP_ADD, 1'b0, x, y, z);
            end
         end

         // now and then leave counts standing into the next settings
         if (phase == RANDOM_PHASES - 1 || $urandom_range(0, 3) != 0)
            send_req(OP_FLUSH, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
         drain(DRAIN_LIMIT);
         steady = 1'b0;
      end

      if (fail_count == 0 && reports_due == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/ewh_pkg.sv
design/ewh_channels.sv
design/ewh_ram.sv
design/ewh_mul.sv
design/ewh_csr.sv
design/equal_width_histogram.sv
verif/ewh_scoreboard.sv
verif/equal_width_histogram_tb.sv
